// File: rtl/sstm_pkg.sv
// ----------------------------------------------------------------------------
// sstm_pkg
// Shared constants, codes and types of the sliding SAD template matcher.
// ----------------------------------------------------------------------------
package sstm_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_LINE   = 1024;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 13;
  localparam int SAD_W      = 13;
  localparam int START_W    = 10;
  localparam int OP_W       = 2;
  localparam int COL_W      = 5;
  localparam int WW_W       = 6;
  localparam int ROWS_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam int CELL_IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int POS_W      = $clog2(MAX_LINE + 1);
  localparam int LIDX_W     = $clog2(MAX_LINE);
  localparam int CMP_W      = ((POS_W > WCNT_W) ? POS_W : WCNT_W) + 1;
  localparam int PSUM_W     = $clog2(MAX_WIDTH * ((1 << PIX_W) - 1) + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [SAD_W-1:0] SAD_MAX = '1;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_ROWS = 1'd1;

  typedef struct packed {
    logic             shift;
    logic             clr;
    logic             add;
    logic             tval_we;
    logic [PIX_W-1:0] add_val;
    logic [PIX_W-1:0] tval;
    logic [PIX_W-1:0] bcast;
  } cell_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/sstm_in_if.sv
// ----------------------------------------------------------------------------
// sstm_in_if
// Input channel: operation beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sstm_in_if;
  import sstm_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [COL_W-1:0] column;
  logic [PIX_W-1:0] intensity;
  logic             line_end;

  modport source (output valid, output op, output column, output intensity,
                  output line_end, input ready);
  modport sink   (input valid, input op, input column, input intensity,
                  input line_end, output ready);
endinterface

// File: rtl/sstm_out_if.sv
// ----------------------------------------------------------------------------
// sstm_out_if
// Result channel: match beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sstm_out_if;
  import sstm_pkg::*;

  logic               valid;
  logic               ready;
  logic [SAD_W-1:0]   sad;
  logic [START_W-1:0] window_start;
  logic               valid_res;
  logic               line_done;

  modport source (output valid, output sad, output window_start,
                  output valid_res, output line_done, input ready);
  modport sink   (input valid, input sad, input window_start,
                  input valid_res, input line_done, output ready);
endinterface

// File: rtl/sstm_cell.sv
// ----------------------------------------------------------------------------
// sstm_cell
// One column of the matcher: delay line tap, template sum and value, and
// the partial SAD handed on to the next cell.
// ----------------------------------------------------------------------------
module sstm_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sstm_pkg::cell_ctl_t          ctl,
  input  logic                         sel,
  input  logic [sstm_pkg::PIX_W-1:0]   samp_in,
  input  logic [sstm_pkg::PSUM_W-1:0]  psum_in,
  output logic [sstm_pkg::PIX_W-1:0]   samp_out,
  output logic [sstm_pkg::PSUM_W-1:0]  psum_out,
  output logic [sstm_pkg::SUM_W-1:0]   tsum_out
);
  import sstm_pkg::*;

  logic [PIX_W-1:0]  samp_r, samp_nxt;
  logic [PSUM_W-1:0] psum_r, psum_nxt;
  logic [SUM_W-1:0]  tsum_r, tsum_nxt;
  logic [PIX_W-1:0]  tval_r, tval_nxt;
  logic [PIX_W-1:0]  diff;
  logic [SUM_W:0]    tsum_add;

  always_comb begin
    diff     = (ctl.bcast >= tval_r) ? (ctl.bcast - tval_r) : (tval_r - ctl.bcast);
    tsum_add = {1'b0, tsum_r} + (SUM_W+1)'(ctl.add_val);
    samp_nxt = samp_r;
    psum_nxt = psum_r;
    tsum_nxt = tsum_r;
    tval_nxt = tval_r;
    if (ctl.shift) begin
      samp_nxt = samp_in;
      psum_nxt = psum_in + PSUM_W'(diff);
    end
    if (ctl.clr) begin
      tsum_nxt = '0;
      tval_nxt = '0;
    end else begin
      if (ctl.add && sel) begin
        tsum_nxt = tsum_add[SUM_W] ? SUM_MAX : tsum_add[SUM_W-1:0];
      end
      if (ctl.tval_we && sel) begin
        tval_nxt = ctl.tval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_r <= '0;
      psum_r <= '0;
      tsum_r <= '0;
      tval_r <= '0;
    end else begin
      samp_r <= samp_nxt;
      psum_r <= psum_nxt;
      tsum_r <= tsum_nxt;
      tval_r <= tval_nxt;
    end
  end

  assign samp_out = samp_r;
  assign psum_out = psum_r;
  assign tsum_out = tsum_r;

endmodule

// File: rtl/sstm_div.sv
// ----------------------------------------------------------------------------
// sstm_div
// Bit-serial restoring divider: template sum over row count, one quotient
// bit per cycle, result clamped to the pixel range.
// ----------------------------------------------------------------------------
module sstm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sstm_pkg::SUM_W-1:0]   dividend,
  input  logic [sstm_pkg::ROWS_W-1:0]  divisor,
  output sstm_pkg::div_stat_t          stat,
  output logic [sstm_pkg::PIX_W-1:0]   quot
);
  import sstm_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  num_r, num_nxt;
  logic [ROWS_W-1:0] rem_r, rem_nxt;
  logic [ROWS_W-1:0] dvs_r, dvs_nxt;
  logic [ROWS_W:0]   trial;
  logic              fits;

  always_comb begin
    trial    = {rem_r, num_r[SUM_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[SUM_W-2:0], fits};
      rem_nxt = fits ? ROWS_W'(trial - {1'b0, dvs_r}) : ROWS_W'(trial);
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = (|num_r[SUM_W-1:PIX_W]) ? '1 : num_r[PIX_W-1:0];

endmodule

// File: rtl/sliding_sad_template_match.sv
// ----------------------------------------------------------------------------
// sliding_sad_template_match
// Sliding sum-of-absolute-differences matcher of scan lines against a mean
// template.
//
// in_if carries operation beats: clear, template add, scan sample. out_if
// carries one match beat per scan sample once the window is full, and a
// marker beat for a line that ends short of the window. cfg_we/cfg_index/
// cfg_wdata write window_width and template_rows; the user is to write them
// only while the block is idle; the block does not enforce it. Scan samples
// enter a row of cells, one per template column, with the sample broadcast
// to all cells and partial sums passed down the row; a scan beat is taken
// every cycle unless out_if stalls or the template is busy, and its result
// passes the match and output registers. A template add uses the divider.
// After any template change the first scan beat waits while the partial
// sums are rebuilt by replaying the delay line. A write of template_rows
// starts a pass that recomputes every template value through the divider,
// during which in_if is held off. Reset clears template, delay line, line
// position and all beats in flight. When out_if stalls, one result waits in
// the output register and one more behind it; the input then stops.
// ----------------------------------------------------------------------------
module sliding_sad_template_match (
  input  logic                            clk,
  input  logic                            rst_n,
  sstm_in_if.sink                         in_if,
  sstm_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [sstm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sstm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sstm_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_REPLAY
  } state_t;

  state_t              st_r, st_nxt;
  logic [WW_W-1:0]     ww_r, ww_nxt;
  logic [ROWS_W-1:0]   rows_r, rows_nxt;
  logic                tdirty_r, tdirty_nxt;
  logic                pstale_r, pstale_nxt;
  logic                sweep_r, sweep_nxt;
  logic [CELL_IDX_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;

  logic                m_valid_r, m_valid_nxt;
  logic                m_res_r, m_res_nxt;
  logic                m_done_r, m_done_nxt;
  logic [START_W-1:0]  m_start_r, m_start_nxt;

  logic                o_valid_r, o_valid_nxt;
  logic [SAD_W-1:0]    o_sad_r, o_sad_nxt;
  logic [START_W-1:0]  o_start_r, o_start_nxt;
  logic                o_res_r, o_res_nxt;
  logic                o_done_r, o_done_nxt;

  logic [PIX_W-1:0]    samp_q [MAX_WIDTH];
  logic [PSUM_W-1:0]   psum_q [MAX_WIDTH];
  logic [SUM_W-1:0]    tsum_q [MAX_WIDTH];

  cell_ctl_t           ctl;
  div_stat_t           dstat;
  logic [PIX_W-1:0]    quot;
  logic                div_start;
  logic [SUM_W-1:0]    dividend;
  logic [SUM_W:0]      div_sum;
  logic [CELL_IDX_W-1:0] rd_col;
  logic [CELL_IDX_W-1:0] sel_col;
  logic [ROWS_W-1:0]   rows_eff;
  logic [WCNT_W-1:0]   w_eff;
  logic [CELL_IDX_W-1:0] tap;
  logic [PSUM_W-1:0]   p_tap;
  logic [LIDX_W-1:0]   idx;
  logic                has_res;
  logic [START_W-1:0]  win_start;
  logic                m_move, slot_ok, acc, col_ok;
  logic                is_clr, is_add, is_scan;
  logic                start_sweep, start_replay, sweep_more, last_col;

  always_comb begin
    if (ww_r == '0) begin
      w_eff = WCNT_W'(1);
    end else if (int'(ww_r) > MAX_WIDTH) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(ww_r);
    end
    rows_eff = (rows_r == '0) ? ROWS_W'(1) : rows_r;
    tap      = CELL_IDX_W'(w_eff - 1'b1);
    p_tap    = psum_q[tap];

    if (int'(pos_r) >= MAX_LINE) begin
      idx = LIDX_W'(MAX_LINE - 1);
    end else begin
      idx = LIDX_W'(pos_r);
    end
    has_res   = (CMP_W'(idx) + CMP_W'(1)) >= CMP_W'(w_eff);
    win_start = START_W'(CMP_W'(idx) + CMP_W'(1) - CMP_W'(w_eff));

    m_move  = m_valid_r && (!o_valid_r || out_if.ready);
    slot_ok = !m_valid_r || m_move;
    in_if.ready = (st_r == ST_RUN) && !tdirty_r && slot_ok &&
                  !(pstale_r && (in_if.op == OP_SCAN));
    acc     = in_if.valid && in_if.ready;
    col_ok  = int'(in_if.column) < MAX_WIDTH;
    is_clr  = acc && (in_if.op == OP_CLEAR);
    is_add  = acc && (in_if.op == OP_ADD) && col_ok;
    is_scan = acc && (in_if.op == OP_SCAN);

    start_sweep  = (st_r == ST_RUN) && tdirty_r;
    start_replay = (st_r == ST_RUN) && !tdirty_r && pstale_r && in_if.valid &&
                   (in_if.op == OP_SCAN) && !m_valid_r;
    last_col     = col_r == CELL_IDX_W'(MAX_WIDTH - 1);
    sweep_more   = sweep_r && !last_col;
    div_start    = start_sweep || is_add ||
                   ((st_r == ST_DIV) && dstat.done && sweep_more);

    if (st_r == ST_RUN) begin
      rd_col  = tdirty_r ? '0 : CELL_IDX_W'(in_if.column);
      sel_col = CELL_IDX_W'(in_if.column);
    end else begin
      rd_col  = col_r + 1'b1;
      sel_col = col_r;
    end
    div_sum  = {1'b0, tsum_q[rd_col]} + (SUM_W+1)'(is_add ? in_if.intensity : '0);
    dividend = div_sum[SUM_W] ? SUM_MAX : div_sum[SUM_W-1:0];

    ctl.shift   = is_scan || (st_r == ST_REPLAY);
    ctl.bcast   = (st_r == ST_REPLAY) ? samp_q[MAX_WIDTH-1] : in_if.intensity;
    ctl.clr     = is_clr;
    ctl.add     = is_add;
    ctl.add_val = in_if.intensity;
    ctl.tval_we = (st_r == ST_DIV) && dstat.done;
    ctl.tval    = quot;
  end

  // control and output registers
  always_comb begin
    st_nxt      = st_r;
    ww_nxt      = ww_r;
    rows_nxt    = rows_r;
    tdirty_nxt  = tdirty_r;
    pstale_nxt  = pstale_r;
    sweep_nxt   = sweep_r;
    col_nxt     = col_r;
    pos_nxt     = pos_r;
    m_valid_nxt = m_move ? 1'b0 : m_valid_r;
    m_res_nxt   = m_res_r;
    m_done_nxt  = m_done_r;
    m_start_nxt = m_start_r;
    o_valid_nxt = o_valid_r;
    o_sad_nxt   = o_sad_r;
    o_start_nxt = o_start_r;
    o_res_nxt   = o_res_r;
    o_done_nxt  = o_done_r;

    case (st_r)
      ST_RUN: begin
        if (start_sweep) begin
          st_nxt     = ST_DIV;
          sweep_nxt  = 1'b1;
          col_nxt    = '0;
          tdirty_nxt = 1'b0;
        end else if (start_replay) begin
          st_nxt  = ST_REPLAY;
          col_nxt = '0;
        end else if (is_add) begin
          st_nxt     = ST_DIV;
          sweep_nxt  = 1'b0;
          col_nxt    = CELL_IDX_W'(in_if.column);
          pstale_nxt = 1'b1;
        end
        if (is_clr) begin
          pstale_nxt = 1'b1;
          pos_nxt    = '0;
        end
        if (is_scan) begin
          if (in_if.line_end) begin
            pos_nxt = '0;
          end else if (int'(pos_r) < MAX_LINE) begin
            pos_nxt = pos_r + 1'b1;
          end
          if (has_res || in_if.line_end) begin
            m_valid_nxt = 1'b1;
            m_res_nxt   = has_res;
            m_done_nxt  = in_if.line_end;
            m_start_nxt = has_res ? win_start : '0;
          end
        end
      end
      ST_DIV: begin
        if (dstat.done) begin
          if (sweep_more) begin
            col_nxt = col_r + 1'b1;
          end else begin
            st_nxt = ST_RUN;
            if (sweep_r) begin
              pstale_nxt = 1'b1;
            end
          end
        end
      end
      ST_REPLAY: begin
        col_nxt = col_r + 1'b1;
        if (last_col) begin
          st_nxt     = ST_RUN;
          pstale_nxt = 1'b0;
        end
      end
      default: begin
        st_nxt = ST_RUN;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_WIDTH: begin
          ww_nxt = cfg_wdata[WW_W-1:0];
        end
        REG_TEMPLATE_ROWS: begin
          rows_nxt   = cfg_wdata[ROWS_W-1:0];
          tdirty_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (m_move) begin
      o_valid_nxt = 1'b1;
      o_res_nxt   = m_res_r;
      o_done_nxt  = m_done_r;
      o_start_nxt = m_start_r;
      if (!m_res_r) begin
        o_sad_nxt = '0;
      end else if (32'(p_tap) > 32'(SAD_MAX)) begin
        o_sad_nxt = SAD_MAX;
      end else begin
        o_sad_nxt = SAD_W'(p_tap);
      end
    end else if (out_if.ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_RUN;
      ww_r      <= WW_W'(7);
      rows_r    <= ROWS_W'(3);
      tdirty_r  <= 1'b0;
      pstale_r  <= 1'b0;
      sweep_r   <= 1'b0;
      col_r     <= '0;
      pos_r     <= '0;
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      ww_r      <= ww_nxt;
      rows_r    <= rows_nxt;
      tdirty_r  <= tdirty_nxt;
      pstale_r  <= pstale_nxt;
      sweep_r   <= sweep_nxt;
      col_r     <= col_nxt;
      pos_r     <= pos_nxt;
      m_valid_r <= m_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
    m_res_r   <= m_res_nxt;
    m_done_r  <= m_done_nxt;
    m_start_r <= m_start_nxt;
    o_sad_r   <= o_sad_nxt;
    o_start_r <= o_start_nxt;
    o_res_r   <= o_res_nxt;
    o_done_r  <= o_done_nxt;
  end

  // row of cells
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    logic [PIX_W-1:0]  samp_src;
    logic [PSUM_W-1:0] psum_src;
    if (i == 0) begin : g_head
      assign samp_src = ctl.bcast;
      assign psum_src = '0;
    end else begin : g_link
      assign samp_src = samp_q[i-1];
      assign psum_src = psum_q[i-1];
    end
    sstm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sel      (sel_col == CELL_IDX_W'(i)),
      .samp_in  (samp_src),
      .psum_in  (psum_src),
      .samp_out (samp_q[i]),
      .psum_out (psum_q[i]),
      .tsum_out (tsum_q[i])
    );
  end

  sstm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (rows_eff),
    .stat     (dstat),
    .quot     (quot)
  );

  assign out_if.valid        = o_valid_r;
  assign out_if.sad          = o_sad_r;
  assign out_if.window_start = o_start_r;
  assign out_if.valid_res    = o_res_r;
  assign out_if.line_done    = o_done_r;

endmodule
